/* rtl/bpt_pkg.sv */
package bpt_pkg;

    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int SQ_W    = 18;
    localparam int NSQ_W   = 16;
    localparam int BOUND_W = 34;
    localparam int REM_W   = 16;

    localparam logic [PIX_W-1:0] KEY_BLACK   = 24'h000000;
    localparam logic [PIX_W-1:0] KEY_MAGENTA = 24'hFF00FF;

    // 3 * 255 * 255: the squared full-scale brightness times three.
    localparam logic [SQ_W-1:0] RMS_SCALE = 18'd195075;

    typedef enum logic [1:0] {
        CFG_TINT_RED   = 2'd0,
        CFG_TINT_GREEN = 2'd1,
        CFG_TINT_BLUE  = 2'd2,
        CFG_STEP_COUNT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic             key;
        logic             zero;
        logic [PIX_W-1:0] pixel;
    } ctl_t;

    typedef struct packed {
        ctl_t               ctl;
        logic [BOUND_W-1:0] bound;
        logic [BOUND_W-1:0] acc;
        logic [CH_W-1:0]    t;
    } root_t;

    typedef struct packed {
        ctl_t                          ctl;
        logic [NUM_CH-1:0][REM_W-1:0]  rem;
        logic [NUM_CH-1:0][CH_W-1:0]   quo;
    } div_t;

endpackage

/* rtl/bpt_front.sv */
module bpt_front
    import bpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_up,
    output logic             ready_up,
    input  logic [PIX_W-1:0] pixel,
    input  logic [CH_W-1:0]  step_count,
    output logic             valid_dn,
    input  logic             ready_dn,
    output root_t            data_dn
);

    logic              s1_valid_reg;
    ctl_t              s1_ctl_reg;
    ctl_t              s1_ctl_next;
    logic [SQ_W-1:0]   s1_sumsq_reg;
    logic [SQ_W-1:0]   s1_sumsq_next;
    logic [NSQ_W-1:0]  s1_nsq_reg;
    logic [NSQ_W-1:0]  s1_nsq_next;
    logic              s2_valid_reg;
    root_t             s2_data_reg;
    root_t             s2_data_next;
    logic              s1_ready;
    logic              s2_ready;
    logic [15:0]       sq_r;
    logic [15:0]       sq_g;
    logic [15:0]       sq_b;

    assign s2_ready = !s2_valid_reg || ready_dn;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign ready_up = s1_ready;

    always_comb
    begin
        sq_r = 16'(pixel[23:16]) * 16'(pixel[23:16]);
        sq_g = 16'(pixel[15:8]) * 16'(pixel[15:8]);
        sq_b = 16'(pixel[7:0]) * 16'(pixel[7:0]);
        s1_sumsq_next = 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
        s1_nsq_next = 16'(step_count) * 16'(step_count);
        s1_ctl_next.key = (pixel == KEY_BLACK) || (pixel == KEY_MAGENTA);
        s1_ctl_next.zero = (step_count == '0);
        s1_ctl_next.pixel = pixel;
    end

    always_comb
    begin
        s2_data_next.ctl = s1_ctl_reg;
        s2_data_next.bound = BOUND_W'(s1_nsq_reg) * BOUND_W'(s1_sumsq_reg);
        s2_data_next.acc = '0;
        s2_data_next.t = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= valid_up;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s1_sumsq_reg <= s1_sumsq_next;
            s1_nsq_reg <= s1_nsq_next;
        end
        if (s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign valid_dn = s2_valid_reg;
    assign data_dn = s2_data_reg;

endmodule

/* rtl/bpt_root_cell.sv */
module bpt_root_cell
    import bpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] bit_idx,
    input  logic       valid_up,
    output logic       ready_up,
    input  root_t      data_up,
    output logic       valid_dn,
    input  logic       ready_dn,
    output root_t      data_dn
);

    logic               valid_reg;
    root_t              data_reg;
    root_t              data_next;
    logic [15:0]        inc;
    logic [BOUND_W-1:0] cand;

    assign ready_up = !valid_reg || ready_dn;

    // Trying bit k on top of t adds 2^(k+1)*t + 4^k to t squared, so the
    // scaled square is kept as a running sum and never recomputed.
    always_comb
    begin
        inc = (16'(data_up.t) << (bit_idx + 3'd1)) + (16'd1 << {bit_idx, 1'b0});
        cand = data_up.acc + BOUND_W'(RMS_SCALE) * BOUND_W'(inc);
        data_next = data_up;
        if (cand <= data_up.bound)
        begin
            data_next.acc = cand;
            data_next.t = data_up.t | (8'd1 << bit_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_dn = valid_reg;
    assign data_dn = data_reg;

endmodule

/* rtl/bpt_div_cell.sv */
module bpt_div_cell
    import bpt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      bit_idx,
    input  logic [CH_W-1:0] divisor,
    input  logic            valid_up,
    output logic            ready_up,
    input  div_t            data_up,
    output logic            valid_dn,
    input  logic            ready_dn,
    output div_t            data_dn
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [REM_W-1:0] dsh;

    assign ready_up = !valid_reg || ready_dn;

    // One restoring division step for each colour channel.
    always_comb
    begin
        dsh = 16'(divisor) << bit_idx;
        data_next = data_up;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (data_up.rem[c] >= dsh)
            begin
                data_next.rem[c] = data_up.rem[c] - dsh;
                data_next.quo[c] = data_up.quo[c] | (8'd1 << bit_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_dn = valid_reg;
    assign data_dn = data_reg;

endmodule

/* rtl/brightness_posterize_tint.sv */
// Throughput: one item per cycle; each stage holds its item only while the
// stage after it is full and stalled, so bubbles close up under back-pressure.
// The brightness step comes from eight root cells and the tint scaling from
// eight division cells, one result bit per cell.
// Reset clears all valid flags; the tint resets to white and the step count to 1.
module brightness_posterize_tint
    import bpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] pixel_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] pixel_out,
    output logic             passed_through,
    input  logic             cfg_wen,
    input  logic [1:0]       cfg_index,
    input  logic [CH_W-1:0]  cfg_data
);

    logic [CH_W-1:0] tint_red_reg;
    logic [CH_W-1:0] tint_green_reg;
    logic [CH_W-1:0] tint_blue_reg;
    logic [CH_W-1:0] step_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_red_reg <= 8'd255;
            tint_green_reg <= 8'd255;
            tint_blue_reg <= 8'd255;
            step_count_reg <= 8'd1;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TINT_RED:   tint_red_reg <= cfg_data;
                CFG_TINT_GREEN: tint_green_reg <= cfg_data;
                CFG_TINT_BLUE:  tint_blue_reg <= cfg_data;
                CFG_STEP_COUNT: step_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic  front_ready;
    logic  root_valid [0:8];
    logic  root_ready [0:8];
    root_t root_data  [0:8];

    bpt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_up   (in_valid),
        .ready_up   (front_ready),
        .pixel      (pixel_in),
        .step_count (step_count_reg),
        .valid_dn   (root_valid[0]),
        .ready_dn   (root_ready[0]),
        .data_dn    (root_data[0])
    );

    assign in_stall = !front_ready;

    for (genvar i = 0; i < 8; i++)
    begin : g_root
        bpt_root_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bit_idx  (3'(7 - i)),
            .valid_up (root_valid[i]),
            .ready_up (root_ready[i]),
            .data_up  (root_data[i]),
            .valid_dn (root_valid[i+1]),
            .ready_dn (root_ready[i+1]),
            .data_dn  (root_data[i+1])
        );
    end

    // Scaling stage: the tint times the brightness step forms each dividend.
    logic div_valid [0:8];
    logic div_ready [0:8];
    div_t div_data  [0:8];
    logic scale_valid_reg;
    div_t scale_data_reg;
    div_t scale_data_next;

    assign root_ready[8] = !scale_valid_reg || div_ready[0];

    always_comb
    begin
        scale_data_next.ctl = root_data[8].ctl;
        scale_data_next.rem[2] = 16'(tint_red_reg) * 16'(root_data[8].t);
        scale_data_next.rem[1] = 16'(tint_green_reg) * 16'(root_data[8].t);
        scale_data_next.rem[0] = 16'(tint_blue_reg) * 16'(root_data[8].t);
        scale_data_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= 1'b0;
        end
        else if (root_ready[8])
        begin
            scale_valid_reg <= root_valid[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (root_ready[8])
        begin
            scale_data_reg <= scale_data_next;
        end
    end

    assign div_valid[0] = scale_valid_reg;
    assign div_data[0] = scale_data_reg;

    for (genvar i = 0; i < 8; i++)
    begin : g_div
        bpt_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bit_idx  (3'(7 - i)),
            .divisor  (step_count_reg),
            .valid_up (div_valid[i]),
            .ready_up (div_ready[i]),
            .data_up  (div_data[i]),
            .valid_dn (div_valid[i+1]),
            .ready_dn (div_ready[i+1]),
            .data_dn  (div_data[i+1])
        );
    end

    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic [PIX_W-1:0] pixel_out_next;
    logic             passed_reg;

    assign div_ready[8] = !out_valid_reg || !out_stall;

    // Key colours and a zero step count leave the pixel as it came in.
    always_comb
    begin
        if (div_data[8].ctl.key || div_data[8].ctl.zero)
        begin
            pixel_out_next = div_data[8].ctl.pixel;
        end
        else
        begin
            pixel_out_next = {div_data[8].quo[2], div_data[8].quo[1], div_data[8].quo[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_ready[8])
        begin
            out_valid_reg <= div_valid[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready[8])
        begin
            pixel_out_reg <= pixel_out_next;
            passed_reg <= div_data[8].ctl.key;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign passed_through = passed_reg;

endmodule
